FILE: src/bile_pkg.sv
// ----------------------------------------------------------------------------
// bile_pkg: shared types and codes for the bounded integer list engine
// Command and result payloads, operation and status codes, cell control.
// ----------------------------------------------------------------------------
package bile_pkg;

	// operation codes
	localparam logic [3:0] FN_APPEND   = 4'd0;
	localparam logic [3:0] FN_PREPEND  = 4'd1;
	localparam logic [3:0] FN_REMOVE   = 4'd2;
	localparam logic [3:0] FN_RM_LAST  = 4'd3;
	localparam logic [3:0] FN_RM_FIRST = 4'd4;
	localparam logic [3:0] FN_CLEAR    = 4'd5;
	localparam logic [3:0] FN_INCLUDES = 4'd6;
	localparam logic [3:0] FN_GET      = 4'd7;
	localparam logic [3:0] FN_POP      = 4'd8;
	localparam logic [3:0] FN_FIRST    = 4'd9;
	localparam logic [3:0] FN_LAST     = 4'd10;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// cell update modes
	localparam logic [1:0] MD_HOLD = 2'd0;
	localparam logic [1:0] MD_LOAD = 2'd1;
	localparam logic [1:0] MD_UP   = 2'd2;
	localparam logic [1:0] MD_DOWN = 2'd3;

	typedef struct packed {
		logic [3:0]         func;
		logic signed [31:0] item;
		logic [5:0]         index;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               found;
		logic [6:0]         fill_level;
		logic [1:0]         status;
	} res_t;

	// scan token walking down the row of cells
	typedef struct packed {
		logic               vld;
		logic               del;
		logic signed [31:0] dat;
	} tok_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       rm;    // close the gap after the first match
		logic       chk;   // compare against the key
		logic       rd;    // capture the target entry
		logic       live;  // position below the fill count
		logic       tgt;   // position is the read target
	} cell_ctl_t;

endpackage

FILE: src/bile_cell.sv
// ----------------------------------------------------------------------------
// bile_cell: one list position
// Holds one entry, shifts with its neighbors and processes the scan token.
// ----------------------------------------------------------------------------
module bile_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  bile_pkg::cell_ctl_t ctl,
	input  logic signed [31:0]  item,
	input  logic signed [31:0]  key,
	input  logic signed [31:0]  left,
	input  logic signed [31:0]  right,
	input  bile_pkg::tok_t      tok_in,
	output logic signed [31:0]  entry,
	output bile_pkg::tok_t      tok_out
);
	import bile_pkg::*;

	logic signed [31:0] entry_q;
	tok_t               tok_q;
	logic               hit;
	logic               del;

	assign hit   = tok_q.vld && ctl.live && ctl.chk && (entry_q == key);
	assign del   = tok_q.del || hit;
	assign entry = entry_q;

	always_comb begin
		tok_out     = tok_q;
		tok_out.del = del;
		tok_out.dat = (tok_q.vld && ctl.rd && ctl.tgt) ? entry_q : tok_q.dat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.mode)
			MD_LOAD: entry_q <= item;
			MD_UP:   entry_q <= left;
			MD_DOWN: entry_q <= right;
			MD_HOLD: begin
				// gap closes as the token passes the match and everything after it
				if (tok_q.vld && ctl.rm && del) entry_q <= right;
			end
		endcase
	end

endmodule

FILE: src/bounded_int_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_int_list_engine: fixed capacity ordered list of signed words
// A row of cells holds the list; a token walks the row for searches and reads.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  cmd     | in  | cmd_valid, cmd_stall | bile_pkg::cmd_t (func, item, index)
//  res     | out | res_valid, res_stall | bile_pkg::res_t (value, found, fill_level, status)
//
//  Append, prepend, remove last/first, clear, first, error cases, and includes or
//  remove value on an empty list: no scan; the result enters the done stage.
//  Includes, remove value, get, pop, last otherwise run a scan, with the token
//  stepping one cell per cycle down the whole row; cmd_stall stays high meanwhile.
//  Reset empties the list (fill count zero); entries are not cleared.
//  A result waits in a done stage and the output register; res_stall holds both.
// ----------------------------------------------------------------------------
module bounded_int_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  bile_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output bile_pkg::res_t res
);
	import bile_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 6) ? CW : 6;

	logic [CW-1:0]      fill_q;
	logic               busy_q;
	logic               rm_q, chk_q, rd_q, pop_q;
	logic signed [31:0] key_q;
	logic [CW-1:0]      tgt_q;
	logic               done_v_q;
	res_t               done_q;
	logic               res_valid_q;
	res_t               res_q;

	logic               move, acc, full, empty, idx_ok;
	logic               start, app_en, pre_en, dn_en;
	logic               sc_rm, sc_chk, sc_rd, sc_pop;
	logic [CW-1:0]      sc_tgt, imm_fill, end_fill;
	res_t               imm_res, end_res;

	tok_t               tok_link [CAPACITY+1];
	logic signed [31:0] cell_entry [CAPACITY];
	cell_ctl_t          cell_ctl [CAPACITY];
	logic [CAPACITY-1:0] tok_vld;

	assign move      = done_v_q && (!res_valid_q || !res_stall);
	assign cmd_stall = busy_q || (done_v_q && !move);
	assign acc       = cmd_valid && !cmd_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign full   = (fill_q == CW'(CAPACITY));
	assign empty  = (fill_q == '0);
	assign idx_ok = (XW'(cmd.index) < XW'(fill_q));

	always_comb begin
		start    = 1'b0;
		app_en   = 1'b0;
		pre_en   = 1'b0;
		dn_en    = 1'b0;
		sc_rm    = 1'b0;
		sc_chk   = 1'b0;
		sc_rd    = 1'b0;
		sc_pop   = 1'b0;
		sc_tgt   = fill_q - CW'(1);
		imm_fill = fill_q;
		imm_res  = '0;
		unique case (cmd.func)
			FN_APPEND: begin
				if (full) imm_res.status = ST_FULL;
				else begin
					app_en   = 1'b1;
					imm_fill = fill_q + CW'(1);
				end
			end
			FN_PREPEND: begin
				if (full) imm_res.status = ST_FULL;
				else begin
					pre_en   = 1'b1;
					imm_fill = fill_q + CW'(1);
				end
			end
			FN_REMOVE, FN_INCLUDES: begin
				if (!empty) begin
					start  = 1'b1;
					sc_chk = 1'b1;
					sc_rm  = (cmd.func == FN_REMOVE);
				end
			end
			FN_RM_LAST: begin
				if (empty) imm_res.status = ST_EMPTY;
				else imm_fill = fill_q - CW'(1);
			end
			FN_RM_FIRST: begin
				if (empty) imm_res.status = ST_EMPTY;
				else begin
					dn_en    = 1'b1;
					imm_fill = fill_q - CW'(1);
				end
			end
			FN_CLEAR: imm_fill = '0;
			FN_GET: begin
				if (!idx_ok) imm_res.status = ST_RANGE;
				else begin
					start  = 1'b1;
					sc_rd  = 1'b1;
					sc_tgt = CW'(cmd.index);
				end
			end
			FN_POP, FN_LAST: begin
				if (empty) imm_res.status = ST_EMPTY;
				else begin
					start  = 1'b1;
					sc_rd  = 1'b1;
					sc_pop = (cmd.func == FN_POP);
				end
			end
			FN_FIRST: begin
				if (empty) imm_res.status = ST_EMPTY;
				else imm_res.value = cell_entry[0];
			end
			default: ;
		endcase
		imm_res.fill_level = 7'(imm_fill);
	end

	// token enters cell 0 on the transfer of a scanning request
	always_comb begin
		tok_link[0]     = '0;
		tok_link[0].vld = acc && start;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_w, right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid
			assign left_w = cell_entry[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_inner
			assign right_w = cell_entry[i+1];
		end

		always_comb begin
			cell_ctl[i]      = '0;
			cell_ctl[i].mode = MD_HOLD;
			if (acc && app_en && (CW'(i) == fill_q)) cell_ctl[i].mode = MD_LOAD;
			else if (acc && pre_en) cell_ctl[i].mode = (i == 0) ? MD_LOAD : MD_UP;
			else if (acc && dn_en) cell_ctl[i].mode = MD_DOWN;
			cell_ctl[i].rm   = rm_q;
			cell_ctl[i].chk  = chk_q;
			cell_ctl[i].rd   = rd_q;
			cell_ctl[i].live = (CW'(i) < fill_q);
			cell_ctl[i].tgt  = (CW'(i) == tgt_q);
		end

		bile_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cell_ctl[i]),
			.item    (cmd.item),
			.key     (key_q),
			.left    (left_w),
			.right   (right_w),
			.tok_in  (tok_link[i]),
			.entry   (cell_entry[i]),
			.tok_out (tok_link[i+1])
		);

		assign tok_vld[i] = tok_link[i+1].vld;
	end

	// token leaving the last cell finishes the scan
	always_comb begin
		end_fill = (pop_q || (rm_q && tok_link[CAPACITY].del)) ? fill_q - CW'(1) : fill_q;
		end_res            = '0;
		end_res.value      = rd_q ? tok_link[CAPACITY].dat : '0;
		end_res.found      = chk_q && tok_link[CAPACITY].del;
		end_res.fill_level = 7'(end_fill);
		end_res.status     = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			busy_q      <= 1'b0;
			rm_q        <= 1'b0;
			chk_q       <= 1'b0;
			rd_q        <= 1'b0;
			pop_q       <= 1'b0;
			done_v_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (acc && start) begin
				busy_q <= 1'b1;
				rm_q   <= sc_rm;
				chk_q  <= sc_chk;
				rd_q   <= sc_rd;
				pop_q  <= sc_pop;
			end else if (acc) begin
				fill_q <= imm_fill;
			end else if (tok_link[CAPACITY].vld) begin
				busy_q <= 1'b0;
				fill_q <= end_fill;
			end

			if ((acc && !start) || tok_link[CAPACITY].vld) done_v_q <= 1'b1;
			else if (move) done_v_q <= 1'b0;

			if (move) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && start) begin
			key_q <= cmd.item;
			tgt_q <= sc_tgt;
		end
		if (acc && !start) done_q <= imm_res;
		else if (tok_link[CAPACITY].vld) done_q <= end_res;
		if (move) res_q <= done_q;
	end

	// done stage is always empty while a scan runs
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !done_v_q)
		else $error("done stage occupied during scan");

	a_tok_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one scan token in the row");

	a_tok_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(|tok_vld) |-> busy_q)
		else $error("scan token without a scan in progress");

	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for bounded_int_list_engine
// Drives list requests through the cmd channel, keeps a queue-based copy of
// the list to predict every result, and checks each res transfer in order.
// Covers empty and full lists, range errors, unused codes, backpressure.
// ----------------------------------------------------------------------------
module tb;
	import bile_pkg::*;

	localparam int CAPACITY    = 64;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT  = 4000;
	localparam int PHASE_ITEMS = 150;

	localparam logic [3:0] FN_SPARE_LO = FN_LAST + 4'd1;
	localparam logic [3:0] FN_SPARE_HI = 4'd15;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic res_valid;
	logic res_stall;
	res_t res;

	bounded_int_list_engine #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #5 clk = ~clk;

	// model of the list contents, updated at each accepted cmd transfer
	logic signed [31:0] list_q[$];
	res_t               expected_q[$];

	int  n_err      = 0;
	int  n_sent     = 0;
	int  n_checked  = 0;
	int  n_full     = 0;
	int  n_range    = 0;
	int  n_empty    = 0;
	int  n_found    = 0;
	int  peak_fill  = 0;
	int  burst_left = 0;
	int  idle_cycles = 0;
	bit  no_gaps       = 1'b0;
	bit  long_hold_req = 1'b0;
	bit  hold_active   = 1'b0;

	function automatic res_t list_predict(input cmd_t c);
		res_t r;
		int   hit_at;
		int   i;
		r      = '0;
		hit_at = -1;
		for (i = 0; i < list_q.size(); i++) begin
			if (list_q[i] == c.item) begin
				hit_at = i;
				break;
			end
		end
		case (c.func)
			FN_APPEND: begin
				if (list_q.size() >= CAPACITY) r.status = ST_FULL;
				else list_q.push_back(c.item);
			end
			FN_PREPEND: begin
				if (list_q.size() >= CAPACITY) r.status = ST_FULL;
				else list_q.push_front(c.item);
			end
			FN_REMOVE: begin
				if (hit_at >= 0) begin
					list_q.delete(hit_at);
					r.found = 1'b1;
				end
			end
			FN_RM_LAST: begin
				if (list_q.size() == 0) r.status = ST_EMPTY;
				else void'(list_q.pop_back());
			end
			FN_RM_FIRST: begin
				if (list_q.size() == 0) r.status = ST_EMPTY;
				else void'(list_q.pop_front());
			end
			FN_CLEAR: list_q.delete();
			FN_INCLUDES: r.found = (hit_at >= 0);
			FN_GET: begin
				if (c.index >= list_q.size()) r.status = ST_RANGE;
				else r.value = list_q[c.index];
			end
			FN_POP: begin
				if (list_q.size() == 0) r.status = ST_EMPTY;
				else r.value = list_q.pop_back();
			end
			FN_FIRST: begin
				if (list_q.size() == 0) r.status = ST_EMPTY;
				else r.value = list_q[0];
			end
			FN_LAST: begin
				if (list_q.size() == 0) r.status = ST_EMPTY;
				else r.value = list_q[list_q.size() - 1];
			end
			default: ;
		endcase
		r.fill_level = 7'(list_q.size());
		return r;
	endfunction

	// one cmd transfer; the sender idles between bursts of random length
	task automatic send_req(input logic [3:0] f, input logic signed [31:0] v = '0,
			input logic [5:0] x = '0);
		cmd_t c;
		res_t want;
		int   gap;
		if (!no_gaps && burst_left == 0) begin
			cmd_valid <= 1'b0;
			gap = ($urandom_range(9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 20);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(9) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
		if (burst_left > 0) burst_left--;
		c.func  = f;
		c.item  = v;
		c.index = x;
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (cmd_stall);
		want = list_predict(c);
		expected_q.push_back(want);
		n_sent++;
		if (want.status == ST_FULL)  n_full++;
		if (want.status == ST_RANGE) n_range++;
		if (want.status == ST_EMPTY) n_empty++;
		if (want.found) n_found++;
		if (list_q.size() > peak_fill) peak_fill = list_q.size();
	endtask

	// sender pauses until every pending result has been taken
	task automatic drain();
		cmd_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// often values already in the list, so removes and lookups can hit
	function automatic logic signed [31:0] pick_value();
		int r;
		r = $urandom_range(9);
		if (r < 4 && list_q.size() > 0) return list_q[$urandom_range(list_q.size() - 1)];
		if (r == 4) begin
			case ($urandom_range(3))
				0: return 32'sh8000_0000;
				1: return 32'sh7FFF_FFFF;
				2: return 32'sh0;
				default: return -32'sd1;
			endcase
		end
		if (r < 7) return 32'($urandom_range(15)) - 32'sd8;
		return $urandom();
	endfunction

	function automatic logic [5:0] pick_index();
		if (list_q.size() > 0 && $urandom_range(9) < 7)
			return 6'($urandom_range(list_q.size() - 1));
		return 6'($urandom());
	endfunction

	task automatic send_random(input int ins_w, input int rem_w);
		int         r;
		logic [3:0] f;
		r = $urandom_range(99);
		if (r < 2) f = 4'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
		else if (r < 3) f = FN_CLEAR;
		else if (r < 3 + ins_w) f = $urandom_range(1) ? FN_PREPEND : FN_APPEND;
		else if (r < 3 + ins_w + rem_w) begin
			case ($urandom_range(3))
				0: f = FN_REMOVE;
				1: f = FN_RM_LAST;
				2: f = FN_RM_FIRST;
				default: f = FN_POP;
			endcase
		end else begin
			case ($urandom_range(3))
				0: f = FN_INCLUDES;
				1: f = FN_GET;
				2: f = FN_FIRST;
				default: f = FN_LAST;
			endcase
		end
		send_req(f, pick_value(), pick_index());
	endtask

	// empty-list errors, extreme values, gap closing, unused codes
	task automatic test_directed();
		send_req(FN_POP);
		send_req(FN_FIRST);
		send_req(FN_LAST);
		send_req(FN_RM_LAST);
		send_req(FN_RM_FIRST);
		send_req(FN_GET, 32'sd0, 6'd0);
		send_req(FN_REMOVE, 32'sd5);
		send_req(FN_INCLUDES, 32'sd5);
		send_req(FN_APPEND, 32'sh7FFF_FFFF);
		send_req(FN_APPEND, 32'sh8000_0000);
		send_req(FN_PREPEND, 32'sh0);
		send_req(FN_PREPEND, -32'sd1);
		send_req(FN_INCLUDES, 32'sh8000_0000);
		send_req(FN_GET, 32'sd0, 6'd3);
		send_req(FN_GET, 32'sd0, 6'd63);
		send_req(FN_GET, 32'sd0, 6'd4);
		send_req(FN_FIRST);
		send_req(FN_LAST);
		send_req(FN_REMOVE, 32'sh0);
		send_req(FN_REMOVE, 32'sh0);
		send_req(FN_RM_FIRST);
		send_req(FN_RM_LAST);
		send_req(FN_POP);
		send_req(FN_APPEND, 32'sh5555_5555);
		send_req(FN_SPARE_LO, $urandom(), 6'($urandom()));
		send_req(FN_SPARE_HI, $urandom(), 6'($urandom()));
		send_req(FN_CLEAR);
		drain();
	endtask

	// fill to capacity, hit the full case on both ends, then empty it again
	task automatic test_full_list();
		int i;
		send_req(FN_CLEAR);
		for (i = 0; i < CAPACITY; i++)
			send_req(i[0] ? FN_PREPEND : FN_APPEND, $urandom());
		send_req(FN_APPEND, $urandom());
		send_req(FN_PREPEND, $urandom());
		send_req(FN_GET, 32'sd0, 6'd63);
		send_req(FN_LAST);
		send_req(FN_FIRST);
		send_req(FN_INCLUDES, list_q[17]);
		send_req(FN_REMOVE, list_q[30]);
		send_req(FN_APPEND, $urandom());
		send_req(FN_PREPEND, $urandom());
		while (list_q.size() > 0) begin
			case ($urandom_range(4))
				0: send_req(FN_RM_FIRST);
				1: send_req(FN_RM_LAST);
				2: send_req(FN_POP);
				3: send_req(FN_REMOVE, list_q[$urandom_range(list_q.size() - 1)]);
				default: send_req(FN_GET, 32'sd0, pick_index());
			endcase
		end
		send_req(FN_POP);
		drain();
	endtask

	// receiver holds off while the sender keeps offering back to back
	task automatic test_backpressure();
		int i;
		long_hold_req = 1'b1;
		wait (hold_active);
		@(posedge clk);
		no_gaps = 1'b1;
		for (i = 0; i < 24; i++) send_random(40, 20);
		no_gaps = 1'b0;
		drain();
	endtask

	// phases that grow, balance and shrink the list
	task automatic test_random();
		int ph;
		int n;
		int ins_w;
		int rem_w;
		for (ph = 0; ph < 6; ph++) begin
			case (ph % 3)
				0: begin ins_w = 55; rem_w = 15; end
				1: begin ins_w = 30; rem_w = 30; end
				default: begin ins_w = 15; rem_w = 50; end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) send_random(ins_w, rem_w);
			drain();
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_list();
		test_backpressure();
		test_random();

		drain();
		repeat (4 * CAPACITY) @(posedge clk);
		if (expected_q.size() != 0) begin
			$error("%0d results never arrived", expected_q.size());
			n_err++;
		end
		$display("Run covered %0d requests, %0d results checked, peak fill %0d of %0d",
			n_sent, n_checked, peak_fill, CAPACITY);
		$display("Full rejects %0d, index out of range %0d, empty list %0d, matches %0d",
			n_full, n_range, n_empty, n_found);
		if (n_err == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: stall density changes per segment; one long hold on request
	initial begin : res_side
		int seg;
		int pct;
		res_stall = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			seg = $urandom_range(20, 200);
			case ($urandom_range(3))
				0: pct = 0;
				1: pct = 20;
				2: pct = 50;
				default: pct = 85;
			endcase
			while (seg > 0 && !long_hold_req) begin
				res_stall <= ($urandom_range(99) < pct);
				@(posedge clk);
				seg--;
			end
			if (long_hold_req) begin
				res_stall  <= 1'b1;
				hold_active = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active   = 1'b0;
				long_hold_req = 1'b0;
			end
		end
	end

	always @(posedge clk) begin : res_check
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result transfer: value %0d fill_level %0d status %0d",
					res.value, res.fill_level, res.status);
				n_err++;
			end else begin
				want = expected_q.pop_front();
				n_checked++;
				if (res.value !== want.value) begin
					$error("value: expected %0d, got %0d", want.value, res.value);
					n_err++;
				end
				if (res.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, res.found);
					n_err++;
				end
				if (res.fill_level !== want.fill_level) begin
					$error("fill_level: expected %0d, got %0d", want.fill_level, res.fill_level);
					n_err++;
				end
				if (res.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res.status);
					n_err++;
				end
			end
		end
	end

	// no transfer on either channel for too long means the block hung
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$error("timeout: no transfer for %0d cycles, %0d results pending",
					IDLE_LIMIT, expected_q.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

endmodule
